### design/blz_pkg.sv
package blz_pkg;

  // History ring
  localparam int unsigned HIST_DEPTH = 8192;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Field and register widths
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned STREAM_W = 24;
  localparam int unsigned CAP_W    = 32;
  localparam int unsigned TOKENS_W = 4;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned DIST_W   = 13;

  // Token coding
  localparam logic [LEN_W-1:0]    LEN_BIAS        = LEN_W'(3);
  localparam logic [DIST_W-1:0]   DIST_BIAS       = DIST_W'(3);
  localparam logic [TOKENS_W-1:0] TOKENS_PER_FLAG = TOKENS_W'(8);

  // Register map, indexed by paddr[2]
  localparam logic REG_STREAM_BYTES    = 1'b0;
  localparam logic REG_OUTPUT_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORTAGE = 2'd1,
    ST_OVERRUN  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COPY = 2'b10
  } state_e;

  typedef struct packed {
    logic [7:0] comp_byte;
  } comp_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    status_e    status;
    logic       finished;
  } res_item_t;

  function automatic logic [HIST_AW-1:0] ring_next(input logic [HIST_AW-1:0] ptr);
    logic [HIST_AW-1:0] nxt;
    if (ptr == HIST_AW'(HIST_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

### design/blz_if.sv
interface blz_comp_if;
  import blz_pkg::*;

  logic       valid;
  logic       ready;
  comp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface blz_res_if;
  import blz_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/blz_ram.sv
module blz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/backward_lzss_decompressor.sv
// Backward LZSS decompressor. Feed compressed bytes from the highest address
// down; decompressed bytes come out from the last address down to the first.
// Write output_capacity first, then stream_bytes: the stream_bytes write
// starts a new decode and clears the error state. A literal token or a flag
// byte is taken in a single request. After the low byte of a reference of
// length L (3 to 18), the copy engine reads L history bytes, one per cycle
// while the queue has room, from the single-read-port ring RAM; the last byte
// leaves the RAM in the cycle after its read, and input requests resume once
// it has returned. Results pass through a two-entry queue, so the copy
// keeps one byte per cycle while the consumer keeps up and stalls cleanly
// when it does not. An error produces one status-only result and halts the
// block; after that, or once all stream bytes are consumed, input requests
// are taken and dropped without a result. The history ring is never
// cleared: a reference only reaches bytes written earlier in the same decode.
module backward_lzss_decompressor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blz_pkg::PADDR_W-1:0]   paddr,
  input  logic [blz_pkg::PDATA_W-1:0]   pwdata,
  output logic [blz_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  blz_comp_if.sink                      comp_i,
  blz_res_if.source                     res_o
);
  import blz_pkg::*;

  // Configuration registers
  logic [STREAM_W-1:0] stream_bytes_q;
  logic [CAP_W-1:0]    capacity_q;
  logic                cfg_we;
  logic                cfg_idx;

  // Decoder state
  state_e              state_q, state_d;
  logic [STREAM_W-1:0] rem_q, rem_d;
  logic [CAP_W-1:0]    prod_q, prod_d;
  logic [7:0]          flag_q, flag_d;
  logic [TOKENS_W-1:0] tokens_q, tokens_d;
  logic [7:0]          high_q, high_d;
  logic                await_q, await_d;
  logic                halted_q, halted_d;
  logic [HIST_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [HIST_AW-1:0]  src_ptr_q, src_ptr_d;
  logic [LEN_W-1:0]    copy_left_q, copy_left_d;
  logic                rd_pend_q;
  logic                rd_last_q;

  // Result queue
  res_item_t           fifo_q [2];
  logic                fifo_wp_q;
  logic                fifo_rp_q;
  logic [1:0]          fifo_cnt_q;

  // Datapath
  logic                accept;
  logic                pop;
  logic                push;
  res_item_t           push_item;
  logic                lit_we;
  logic                ram_we;
  logic [7:0]          ram_wdata;
  logic [7:0]          ram_rdata;
  logic                issue;
  logic [2:0]          occ;
  logic [7:0]          in_byte;
  logic [STREAM_W-1:0] rem_dec;
  logic [DIST_W-1:0]   ref_dist;
  logic [LEN_W-1:0]    len;
  logic [CAP_W-1:0]    room;
  logic [HIST_AW:0]    src_diff;
  logic [HIST_AW-1:0]  src_start;

  // Configuration port: always ready, write on access phase.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (cfg_idx)
        REG_STREAM_BYTES:    prdata = PDATA_W'(stream_bytes_q);
        REG_OUTPUT_CAPACITY: prdata = PDATA_W'(capacity_q);
        default:             prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_bytes_q <= '0;
      capacity_q     <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_STREAM_BYTES) begin
        stream_bytes_q <= pwdata[STREAM_W-1:0];
      end else begin
        capacity_q <= pwdata[CAP_W-1:0];
      end
    end
  end

  // Handshakes: take a request only when the copy engine is quiet and the
  // queue has a free slot.
  assign comp_i.ready = (state_q == S_IDLE) && !rd_pend_q && (fifo_cnt_q != 2'd2);
  assign accept       = comp_i.valid & comp_i.ready;
  assign pop          = res_o.valid & res_o.ready;
  assign res_o.valid  = (fifo_cnt_q != 2'd0);
  assign res_o.data   = fifo_q[fifo_rp_q];

  // Token arithmetic
  assign in_byte  = comp_i.data.comp_byte;
  assign rem_dec  = rem_q - 1'b1;
  assign ref_dist = {1'b0, high_q[3:0], in_byte} + DIST_BIAS;
  assign len      = LEN_W'(high_q[7:4]) + LEN_BIAS;
  assign room     = capacity_q - prod_q;
  assign src_diff = {1'b0, wr_ptr_q} - (HIST_AW + 1)'(ref_dist);
  assign src_start = src_diff[HIST_AW]
                   ? HIST_AW'(src_diff + (HIST_AW + 1)'(HIST_DEPTH))
                   : src_diff[HIST_AW-1:0];

  // Issue a ring read only if its byte is sure to find a queue slot.
  assign occ   = 3'(fifo_cnt_q) + 3'(rd_pend_q) - 3'(pop);
  assign issue = (state_q == S_COPY) && (copy_left_q != '0) && (occ <= 3'd1);

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    flag_d      = flag_q;
    tokens_d    = tokens_q;
    high_d      = high_q;
    await_d     = await_q;
    halted_d    = halted_q;
    wr_ptr_d    = wr_ptr_q;
    src_ptr_d   = src_ptr_q;
    copy_left_d = copy_left_q;
    push        = 1'b0;
    push_item   = '{out_byte: '0, byte_valid: 1'b0, run_last: 1'b1,
                    status: ST_OK, finished: 1'b0};
    lit_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && !halted_q && (rem_q != '0)) begin
          if (await_q) begin
            // Reference low byte: check, then hand over to the copy engine.
            rem_d   = rem_dec;
            await_d = 1'b0;
            if (CAP_W'(ref_dist) > prod_q) begin
              push             = 1'b1;
              push_item.status = ST_SHORTAGE;
              halted_d         = 1'b1;
            end else if (CAP_W'(len) > room) begin
              push             = 1'b1;
              push_item.status = ST_OVERRUN;
              halted_d         = 1'b1;
            end else begin
              state_d     = S_COPY;
              copy_left_d = len;
              src_ptr_d   = src_start;
              tokens_d    = (tokens_q != '0) ? tokens_q - 1'b1 : tokens_q;
              flag_d      = {flag_q[6:0], 1'b0};
            end
          end else if (tokens_q == '0) begin
            // Flag byte
            flag_d   = in_byte;
            rem_d    = rem_dec;
            tokens_d = TOKENS_PER_FLAG;
            if (rem_dec == '0) begin
              push             = 1'b1;
              push_item.status = ST_SHORTAGE;
              halted_d         = 1'b1;
            end
          end else if (prod_q >= capacity_q) begin
            // Drop the token byte: no room left.
            push             = 1'b1;
            push_item.status = ST_OVERRUN;
            halted_d         = 1'b1;
          end else if (flag_q[7]) begin
            // Reference high byte; its low byte must still be in the stream.
            if (rem_q < STREAM_W'(2)) begin
              push             = 1'b1;
              push_item.status = ST_SHORTAGE;
              halted_d         = 1'b1;
            end else begin
              high_d  = in_byte;
              rem_d   = rem_dec;
              await_d = 1'b1;
            end
          end else begin
            // Literal
            rem_d                = rem_dec;
            lit_we               = 1'b1;
            push                 = 1'b1;
            push_item.out_byte   = in_byte;
            push_item.byte_valid = 1'b1;
            push_item.finished   = (rem_dec == '0);
            tokens_d = (tokens_q != '0) ? tokens_q - 1'b1 : tokens_q;
            flag_d   = {flag_q[6:0], 1'b0};
          end
        end
      end
      S_COPY: begin
        if (issue) begin
          src_ptr_d   = ring_next(src_ptr_q);
          copy_left_d = copy_left_q - 1'b1;
          if (copy_left_q == LEN_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Ring byte returns: append to the output and to the history.
    if (rd_pend_q) begin
      push                 = 1'b1;
      push_item.out_byte   = ram_rdata;
      push_item.byte_valid = 1'b1;
      push_item.run_last   = rd_last_q;
      push_item.finished   = rd_last_q && (rem_q == '0);
    end

    if (lit_we || rd_pend_q) begin
      wr_ptr_d = ring_next(wr_ptr_q);
      prod_d   = prod_q + 1'b1;
    end

    // A stream_bytes write restarts the decode.
    if (cfg_we && (cfg_idx == REG_STREAM_BYTES)) begin
      state_d     = S_IDLE;
      rem_d       = pwdata[STREAM_W-1:0];
      prod_d      = '0;
      flag_d      = '0;
      tokens_d    = '0;
      high_d      = '0;
      await_d     = 1'b0;
      halted_d    = 1'b0;
      wr_ptr_d    = '0;
      copy_left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rem_q       <= '0;
      prod_q      <= '0;
      flag_q      <= '0;
      tokens_q    <= '0;
      high_q      <= '0;
      await_q     <= 1'b0;
      halted_q    <= 1'b0;
      wr_ptr_q    <= '0;
      src_ptr_q   <= '0;
      copy_left_q <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      prod_q      <= prod_d;
      flag_q      <= flag_d;
      tokens_q    <= tokens_d;
      high_q      <= high_d;
      await_q     <= await_d;
      halted_q    <= halted_d;
      wr_ptr_q    <= wr_ptr_d;
      src_ptr_q   <= src_ptr_d;
      copy_left_q <= copy_left_d;
      rd_pend_q   <= issue;
      rd_last_q   <= issue && (copy_left_q == LEN_W'(1));
    end
  end

  // Result queue: two entries, one push and one pop per cycle.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wp_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= 1'b0;
      fifo_rp_q  <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        fifo_wp_q <= ~fifo_wp_q;
      end
      if (pop) begin
        fifo_rp_q <= ~fifo_rp_q;
      end
      fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
    end
  end

  // History ring: literal and copied bytes are written at the output
  // position; the copy engine reads at least three entries behind it.
  assign ram_we    = lit_we | rd_pend_q;
  assign ram_wdata = rd_pend_q ? ram_rdata : in_byte;

  blz_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (src_ptr_q),
    .rdata_o (ram_rdata)
  );

endmodule
